/* sv/bsch_pkg.sv */
// Shared types and codes for the burst scheduler: process states, operation,
// result and policy codes, register indexes and the inter-module structs.
// No dependencies.
`default_nettype none

package bsch_pkg;

  typedef enum logic [2:0] {
    ST_GONE    = 3'd0,
    ST_HOLD    = 3'd1,
    ST_READY   = 3'd2,
    ST_RUNNING = 3'd3,
    ST_WAITING = 3'd4,
    ST_TERM    = 3'd5
  } proc_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P1,
    S_P1W,
    S_DSCAN,
    S_DISP,
    S_P3,
    S_TEND
  } fsm_state_t;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_BURST = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] KIND_DISP = 2'd0;
  localparam logic [1:0] KIND_COMP = 2'd1;
  localparam logic [1:0] KIND_TEND = 2'd2;
  localparam logic [1:0] KIND_ACK  = 2'd3;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_PRI  = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_QUANTUM = 2'd1;
  localparam logic [1:0] CFG_PCOUNT  = 2'd2;

  localparam logic [5:0] QUANTUM_RESET = 6'd10;

  typedef struct packed {
    logic load;
    logic shift;
  } qcell_ctrl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  pid;
    logic [15:0] etime;
    logic [15:0] wtime;
    logic [15:0] ttime;
    logic        done;
    logic        last;
  } out_beat_t;

endpackage

`default_nettype wire

/* sv/bsch_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bsch_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/bsch_qcell.sv */
// One cell of the ready-queue chain: holds a pid, loads a pushed pid or
// takes its right neighbor's pid on removal. Depends on bsch_pkg.
`default_nettype none

module bsch_qcell #(
  parameter int PIW = 4
) (
  input  logic                   clk,
  input  bsch_pkg::qcell_ctrl_t  ctrl,
  input  logic [PIW-1:0]         push_pid,
  input  logic [PIW-1:0]         next_pid,
  input  logic [PIW-1:0]         probe,
  output logic [PIW-1:0]         pid,
  output logic                   match
);
  import bsch_pkg::*;

  logic [PIW-1:0] pid_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pid_r <= push_pid;
    end else if (ctrl.shift) begin
      pid_r <= next_pid;
    end
  end

  assign pid   = pid_r;
  assign match = (pid_r == probe);

endmodule

`default_nettype wire

/* sv/cpu_burst_scheduler_sim.sv */
// Top level of the tick-driven burst scheduler: sequencer, process table,
// ready-queue cell chain and burst RAM. Depends on bsch_pkg, bsch_qcell, bsch_ram.
//
// Usage. An input beat is taken when start is high and busy is low. Clear,
// header load and burst append keep busy low, and the single acknowledge
// beat shows on the out_ ports in the next cycle, marked by out_strobe for
// exactly one cycle. A tick raises busy and walks the process table one entry
// per cycle for transitions, except that a process that fetches its next
// burst from the burst RAM, whose read is registered, holds the walk in S_P1W;
// then, if the CPU is free and the queue is not empty, it scans the ready queue
// one entry per cycle under SJF or priority and dispatches; it walks the table
// again for counters and completions and ends with the tick-end beat. Result
// beats come at most one per cycle and the receiver cannot stall them.
// Configuration writes on cfg_we take effect at once and are meant for
// idle time only. Reset (rst_n low, synchronous) empties the table and queue,
// frees the CPU, sets the slice to ten and time to zero; the burst RAM and the
// header stores are not cleared and read only after they are written.
`default_nettype none

module cpu_burst_scheduler_sim #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_BURSTS    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_process_index,
  input  logic [15:0] in_arrival_time,
  input  logic [7:0]  in_priority_req,
  input  logic [9:0]  in_burst_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_process_id,
  output logic [15:0] out_event_time,
  output logic [15:0] out_waiting_time,
  output logic [15:0] out_turnaround_time,
  output logic        out_all_done,
  output logic        out_last
);
  import bsch_pkg::*;

  localparam int PIW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW    = $clog2(MAX_PROCESSES + 1);
  localparam int BCW   = $clog2(MAX_BURSTS + 1);
  localparam int DEPTH = MAX_PROCESSES * MAX_BURSTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [1:0] policy_r;
  logic [5:0] quantum_r;
  logic [4:0] pcount_r;

  // Sequencer and scalar state.
  fsm_state_t     state_r, state_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [PIW-1:0] best_pos_r, best_pos_nxt;
  logic [PIW-1:0] best_pid_r, best_pid_nxt;
  logic [9:0]     best_key_r, best_key_nxt;
  logic           done_r, done_nxt;
  proc_state_t    p1_st_r, p1_st_nxt;
  logic           cpu_free_r, cpu_free_nxt;
  logic [5:0]     ql_r, ql_nxt;
  logic [15:0]    tick_r, tick_nxt;
  logic [CW-1:0]  qlen_r, qlen_nxt;

  // Process table.
  proc_state_t    st_r   [MAX_PROCESSES];
  proc_state_t    st_nxt [MAX_PROCESSES];
  logic [15:0]    arr_r  [MAX_PROCESSES];
  logic [15:0]    arr_nxt[MAX_PROCESSES];
  logic [7:0]     pri_r  [MAX_PROCESSES];
  logic [7:0]     pri_nxt[MAX_PROCESSES];
  logic [BCW-1:0] bcnt_r [MAX_PROCESSES];
  logic [BCW-1:0] bcnt_nxt[MAX_PROCESSES];
  logic [BCW-1:0] bpos_r [MAX_PROCESSES];
  logic [BCW-1:0] bpos_nxt[MAX_PROCESSES];
  logic [9:0]     rem_r  [MAX_PROCESSES];
  logic [9:0]     rem_nxt[MAX_PROCESSES];
  logic [15:0]    wc_r   [MAX_PROCESSES];
  logic [15:0]    wc_nxt [MAX_PROCESSES];

  // Output beat register.
  out_beat_t beat_r, beat_nxt;
  logic      strobe_r, strobe_nxt;

  // Ready-queue chain.
  qcell_ctrl_t    q_ctrl [MAX_PROCESSES];
  logic [PIW-1:0] q_pid  [MAX_PROCESSES];
  logic           q_match[MAX_PROCESSES];
  logic           push_en;
  logic [PIW-1:0] push_pid;
  logic           rm_en;
  logic [PIW-1:0] rm_pos;

  // Burst RAM.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [9:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [9:0]    ram_rdata;

  // Working signals.
  logic [CW-1:0]  n_proc;
  logic [PIW-1:0] ix;
  logic [PIW-1:0] lix;
  logic           idx_ok;
  logic [BCW-1:0] pos_n;
  logic           has_next;
  logic [PIW-1:0] cand_pid;
  logic [9:0]     cand_key;
  logic           ld_found;
  logic [PIW-1:0] ld_pos;

  for (genvar c = 0; c < MAX_PROCESSES; c++) begin : g_q
    logic [PIW-1:0] next_pid;
    if (c == MAX_PROCESSES - 1) begin : g_end
      assign next_pid = '0;
    end else begin : g_mid
      assign next_pid = q_pid[c+1];
    end
    assign q_ctrl[c].load  = push_en && (qlen_r == CW'(c));
    assign q_ctrl[c].shift = rm_en && (PIW'(c) >= rm_pos);
    bsch_qcell #(.PIW(PIW)) u_cell (
      .clk      (clk),
      .ctrl     (q_ctrl[c]),
      .push_pid (push_pid),
      .next_pid (next_pid),
      .probe    (lix),
      .pid      (q_pid[c]),
      .match    (q_match[c])
    );
  end

  bsch_ram #(.WIDTH(10), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Processes above MAX_PROCESSES are clamped away.
  always_comb begin
    if (32'(pcount_r) < MAX_PROCESSES) begin
      n_proc = CW'(pcount_r);
    end else begin
      n_proc = CW'(MAX_PROCESSES);
    end
  end

  assign lix    = PIW'(in_process_index);
  assign idx_ok = 32'(in_process_index) < MAX_PROCESSES;
  assign ix     = i_r[PIW-1:0];
  assign pos_n  = BCW'(bpos_r[ix] + BCW'(1));
  assign has_next = (pos_n < bcnt_r[ix]) && (32'(pos_n) < MAX_BURSTS);
  assign cand_pid = q_pid[j_r[PIW-1:0]];
  assign cand_key = (policy_r == POL_SJF) ? rem_r[cand_pid] : {2'b00, pri_r[cand_pid]};

  // First queue slot that holds the pid being reloaded.
  always_comb begin
    ld_found = 1'b0;
    ld_pos   = '0;
    for (int c = 0; c < MAX_PROCESSES; c++) begin
      if (!ld_found && (CW'(c) < qlen_r) && q_match[c]) begin
        ld_found = 1'b1;
        ld_pos   = PIW'(c);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    best_pos_nxt = best_pos_r;
    best_pid_nxt = best_pid_r;
    best_key_nxt = best_key_r;
    done_nxt     = done_r;
    p1_st_nxt    = p1_st_r;
    cpu_free_nxt = cpu_free_r;
    ql_nxt       = ql_r;
    tick_nxt     = tick_r;
    qlen_nxt     = qlen_r;
    st_nxt       = st_r;
    arr_nxt      = arr_r;
    pri_nxt      = pri_r;
    bcnt_nxt     = bcnt_r;
    bpos_nxt     = bpos_r;
    rem_nxt      = rem_r;
    wc_nxt       = wc_r;
    beat_nxt     = '0;
    strobe_nxt   = 1'b0;
    push_en      = 1'b0;
    push_pid     = ix;
    rm_en        = 1'b0;
    rm_pos       = '0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(32'(lix) * MAX_BURSTS + 32'(bcnt_r[lix]));
    ram_wdata    = in_burst_length;
    ram_raddr    = AW'(32'(ix) * MAX_BURSTS + 32'(pos_n));

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          beat_nxt.kind  = KIND_ACK;
          beat_nxt.pid   = in_process_index;
          beat_nxt.etime = tick_r;
          beat_nxt.last  = 1'b1;
          unique case (in_operation)
            OP_CLEAR: begin
              for (int p = 0; p < MAX_PROCESSES; p++) begin
                st_nxt[p]   = ST_GONE;
                bcnt_nxt[p] = '0;
                bpos_nxt[p] = '0;
                rem_nxt[p]  = '0;
                wc_nxt[p]   = '0;
              end
              qlen_nxt       = '0;
              cpu_free_nxt   = 1'b1;
              tick_nxt       = '0;
              ql_nxt         = quantum_r;
              beat_nxt.pid   = '0;
              beat_nxt.etime = '0;
              strobe_nxt     = 1'b1;
            end
            OP_LOAD: begin
              if (idx_ok) begin
                if (ld_found) begin
                  rm_en    = 1'b1;
                  rm_pos   = ld_pos;
                  qlen_nxt = qlen_r - CW'(1);
                end
                if (st_r[lix] == ST_RUNNING) begin
                  cpu_free_nxt = 1'b1;
                end
                st_nxt[lix]   = ST_HOLD;
                arr_nxt[lix]  = in_arrival_time;
                pri_nxt[lix]  = in_priority_req;
                bcnt_nxt[lix] = '0;
                bpos_nxt[lix] = '0;
                rem_nxt[lix]  = '0;
                wc_nxt[lix]   = '0;
              end
              strobe_nxt = 1'b1;
            end
            OP_BURST: begin
              if (idx_ok && (in_burst_length != '0) &&
                  (32'(bcnt_r[lix]) < MAX_BURSTS)) begin
                ram_we = 1'b1;
                if (bcnt_r[lix] == '0) begin
                  rem_nxt[lix] = in_burst_length;
                end
                bcnt_nxt[lix] = BCW'(bcnt_r[lix] + BCW'(1));
              end
              strobe_nxt = 1'b1;
            end
            OP_TICK: begin
              i_nxt     = '0;
              state_nxt = S_P1;
            end
            default: ;
          endcase
        end
      end

      // Transitions, one table entry per cycle unless a burst fetch waits in S_P1W.
      S_P1: begin
        if (i_r < n_proc) begin
          i_nxt = i_r + CW'(1);
          unique case (st_r[ix])
            ST_HOLD: begin
              if (arr_r[ix] == tick_r) begin
                st_nxt[ix] = ST_READY;
                if (32'(qlen_r) < MAX_PROCESSES) begin
                  push_en  = 1'b1;
                  qlen_nxt = qlen_r + CW'(1);
                end
              end
            end
            ST_WAITING: begin
              if (rem_r[ix] == '0) begin
                bpos_nxt[ix] = pos_n;
                if (has_next) begin
                  p1_st_nxt = ST_READY;
                  i_nxt     = i_r;
                  state_nxt = S_P1W;
                end else begin
                  st_nxt[ix] = ST_TERM;
                end
              end
            end
            ST_RUNNING: begin
              if (rem_r[ix] == '0) begin
                cpu_free_nxt = 1'b1;
                bpos_nxt[ix] = pos_n;
                if (has_next) begin
                  p1_st_nxt = ST_WAITING;
                  i_nxt     = i_r;
                  state_nxt = S_P1W;
                end else begin
                  st_nxt[ix] = ST_TERM;
                end
              end else if (policy_r == POL_RR && ql_r == '0) begin
                st_nxt[ix]   = ST_READY;
                cpu_free_nxt = 1'b1;
                if (32'(qlen_r) < MAX_PROCESSES) begin
                  push_en  = 1'b1;
                  qlen_nxt = qlen_r + CW'(1);
                end
              end
            end
            default: ;
          endcase
        end else if (cpu_free_r && qlen_r != '0) begin
          if (policy_r == POL_SJF || policy_r == POL_PRI) begin
            j_nxt     = '0;
            state_nxt = S_DSCAN;
          end else begin
            best_pos_nxt = '0;
            state_nxt    = S_DISP;
          end
        end else begin
          i_nxt     = '0;
          done_nxt  = 1'b1;
          state_nxt = S_P3;
        end
      end

      // The next burst length arrives from the RAM.
      S_P1W: begin
        rem_nxt[ix] = ram_rdata;
        st_nxt[ix]  = p1_st_r;
        if (p1_st_r == ST_READY && 32'(qlen_r) < MAX_PROCESSES) begin
          push_en  = 1'b1;
          qlen_nxt = qlen_r + CW'(1);
        end
        i_nxt     = i_r + CW'(1);
        state_nxt = S_P1;
      end

      // Smallest key over the queue, ties to the smaller pid.
      S_DSCAN: begin
        if (j_r < qlen_r) begin
          if (j_r == '0 || cand_key < best_key_r ||
              (cand_key == best_key_r && cand_pid < best_pid_r)) begin
            best_pos_nxt = j_r[PIW-1:0];
            best_pid_nxt = cand_pid;
            best_key_nxt = cand_key;
          end
          j_nxt = j_r + CW'(1);
        end else begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        rm_en                 = 1'b1;
        rm_pos                = best_pos_r;
        qlen_nxt              = qlen_r - CW'(1);
        st_nxt[q_pid[best_pos_r]] = ST_RUNNING;
        cpu_free_nxt          = 1'b0;
        ql_nxt                = quantum_r;
        beat_nxt.kind         = KIND_DISP;
        beat_nxt.pid          = 4'(q_pid[best_pos_r]);
        beat_nxt.etime        = tick_r;
        strobe_nxt            = 1'b1;
        i_nxt                 = '0;
        done_nxt              = 1'b1;
        state_nxt             = S_P3;
      end

      // Counters and completions, one table entry per cycle.
      S_P3: begin
        if (i_r < n_proc) begin
          i_nxt = i_r + CW'(1);
          unique case (st_r[ix])
            ST_READY: begin
              if (wc_r[ix] != 16'hFFFF) begin
                wc_nxt[ix] = wc_r[ix] + 16'd1;
              end
              done_nxt = 1'b0;
            end
            ST_WAITING: begin
              if (rem_r[ix] != '0) begin
                rem_nxt[ix] = rem_r[ix] - 10'd1;
              end
              done_nxt = 1'b0;
            end
            ST_RUNNING: begin
              if (rem_r[ix] != '0) begin
                rem_nxt[ix] = rem_r[ix] - 10'd1;
              end
              if (ql_r != '0) begin
                ql_nxt = ql_r - 6'd1;
              end
              done_nxt = 1'b0;
            end
            ST_TERM: begin
              st_nxt[ix]     = ST_GONE;
              beat_nxt.kind  = KIND_COMP;
              beat_nxt.pid   = 4'(ix);
              beat_nxt.etime = tick_r;
              beat_nxt.wtime = wc_r[ix];
              beat_nxt.ttime = (tick_r >= arr_r[ix]) ? tick_r - arr_r[ix] : 16'd0;
              strobe_nxt     = 1'b1;
            end
            ST_HOLD: begin
              done_nxt = 1'b0;
            end
            default: ;
          endcase
        end else begin
          state_nxt = S_TEND;
        end
      end

      S_TEND: begin
        beat_nxt.kind  = KIND_TEND;
        beat_nxt.etime = tick_r;
        beat_nxt.done  = done_r;
        beat_nxt.last  = 1'b1;
        strobe_nxt     = 1'b1;
        if (tick_r != 16'hFFFF) begin
          tick_nxt = tick_r + 16'd1;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      policy_r   <= POL_FIFO;
      quantum_r  <= QUANTUM_RESET;
      pcount_r   <= 5'd1;
      i_r        <= '0;
      j_r        <= '0;
      done_r     <= 1'b0;
      p1_st_r    <= ST_GONE;
      cpu_free_r <= 1'b1;
      ql_r       <= QUANTUM_RESET;
      tick_r     <= '0;
      qlen_r     <= '0;
      strobe_r   <= 1'b0;
      for (int p = 0; p < MAX_PROCESSES; p++) begin
        st_r[p]   <= ST_GONE;
        bcnt_r[p] <= '0;
        bpos_r[p] <= '0;
        rem_r[p]  <= '0;
        wc_r[p]   <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      done_r     <= done_nxt;
      p1_st_r    <= p1_st_nxt;
      cpu_free_r <= cpu_free_nxt;
      ql_r       <= ql_nxt;
      tick_r     <= tick_nxt;
      qlen_r     <= qlen_nxt;
      strobe_r   <= strobe_nxt;
      st_r       <= st_nxt;
      bcnt_r     <= bcnt_nxt;
      bpos_r     <= bpos_nxt;
      rem_r      <= rem_nxt;
      wc_r       <= wc_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:  policy_r  <= cfg_data[1:0];
          CFG_QUANTUM: quantum_r <= cfg_data;
          CFG_PCOUNT:  pcount_r  <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    best_pos_r <= best_pos_nxt;
    best_pid_r <= best_pid_nxt;
    best_key_r <= best_key_nxt;
    arr_r      <= arr_nxt;
    pri_r      <= pri_nxt;
    beat_r     <= beat_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = strobe_r;
  assign out_kind            = beat_r.kind;
  assign out_process_id      = beat_r.pid;
  assign out_event_time      = beat_r.etime;
  assign out_waiting_time    = beat_r.wtime;
  assign out_turnaround_time = beat_r.ttime;
  assign out_all_done        = beat_r.done;
  assign out_last            = beat_r.last;

endmodule

`default_nettype wire

/* sv/bsch_chk.sv */
// Port-level checker for the burst scheduler and its bind to the top level.
// Depends on bsch_pkg and cpu_burst_scheduler_sim.
`default_nettype none

module bsch_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_operation,
  input wire logic       out_strobe,
  input wire logic [1:0] out_kind,
  input wire logic       out_all_done,
  input wire logic       out_last
);
  import bsch_pkg::*;

  a_tend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_TEND |-> out_last)
    else $error("tick end beat without last");

  a_disp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == KIND_DISP || out_kind == KIND_COMP) |-> !out_last)
    else $error("dispatch or completion marked last");

  a_done_only_tend: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind != KIND_TEND |-> !out_all_done)
    else $error("all_done outside tick end");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_TICK |=> busy)
    else $error("tick accepted without going busy");

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != OP_TICK |=> out_strobe && out_last && !busy)
    else $error("load beat not acknowledged in next cycle");

endmodule

bind cpu_burst_scheduler_sim bsch_chk u_bsch_chk (.*);

`default_nettype wire
